// ===== hdl/depth_pixel_backprojection_defines.svh =====
// Assertion macros for the depth pixel back-projection block.
// Each macro samples on clk_i and is disabled while rst_ni is low,
// so the including module must have ports of those names.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// The property must hold at every sampled edge.
`define DPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define DPB_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/dpb_pkg.sv =====
// Package for the depth pixel back-projection block.
// Holds the payload struct types and the register index codes.
// No dependencies.
`default_nettype none

package dpb_pkg;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [15:0] depth_mm;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] x_mm;
    logic signed [31:0] y_mm;
    logic [15:0]        z_mm;
    logic [7:0]         point_red;
    logic [7:0]         point_green;
    logic [7:0]         point_blue;
  } point_t;

  typedef enum logic [2:0] {
    REG_MIN_DEPTH   = 3'd0,
    REG_MAX_DEPTH   = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_INV_FOCAL_X = 3'd4,
    REG_INV_FOCAL_Y = 3'd5
  } reg_idx_e;

  localparam logic [15:0] MIN_DEPTH_RESET = 16'd10;
  localparam logic [15:0] MAX_DEPTH_RESET = 16'd2000;

  // Fraction bits of the depth * offset * inverse focal product (Q.4 * Q0.24).
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned PROD_BITS = 56;

endpackage

`default_nettype wire

// ===== hdl/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection block: pinhole model, four stages.
// Depends on dpb_pkg and depth_pixel_backprojection_defines.svh.
//
// Usage:
// One depth pixel (row, column, depth, BGR) is moved per transfer on the input
// channel (in_valid_i / in_stall_o / in_data_i); one camera-space point per
// passing pixel leaves on the output channel (out_valid_o / out_stall_i /
// out_data_o). A pixel passes when row and column are multiples of
// SUBSAMPLE_STEP and the depth lies within the inclusive depth window.
// Rejected pixels simply vanish from the pipeline; no result is produced.
// Throughput is one pixel per clock while the receiver does not stall. Each
// result passes through the registered stages in order: offset subtraction
// and window test, subsample test and offset times depth, times inverse focal
// length, then floor into the output register. The two multipliers set the
// stage split. When the receiver stalls, stages fill up behind the output
// register; in_stall_o rises only once every stage holds a valid item, and
// nothing is dropped or repeated. Reset empties the pipeline and loads the
// register defaults (depth window 10 to 2000 mm, center and focal zero). The
// user writes registers over the APB port while idle; the block does not enforce it.
`default_nettype none

module depth_pixel_backprojection #(
  parameter int SUBSAMPLE_STEP = 3,
  parameter int COORD_BITS     = 12
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire dpb_pkg::pixel_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output dpb_pkg::point_t      out_data_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [4:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

`include "depth_pixel_backprojection_defines.svh"

  // Coordinate width actually used; the input field is 12 bits wide.
  localparam int CW = (COORD_BITS < 12) ? COORD_BITS : 12;
  // Divisibility test: x is a multiple of the step exactly when the low
  // DIV_SHIFT bits of x * DIV_MUL are below DIV_MUL.
  localparam int DIV_SHIFT = CW + $clog2(SUBSAMPLE_STEP);
  localparam int DIV_MUL_W = CW + 2;
  localparam int DIV_MUL_I = ((1 << DIV_SHIFT) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_I);
  localparam int PW = CW + DIV_MUL_W;
  localparam int FB = dpb_pkg::FRAC_BITS;
  localparam int PB = dpb_pkg::PROD_BITS;

  // ---------------------------------------------------------------- registers
  logic [15:0] min_depth_q, max_depth_q, center_x_q, center_y_q;
  logic [23:0] inv_fx_q, inv_fy_q;
  logic        cfg_wr;
  dpb_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = dpb_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_depth_q <= dpb_pkg::MIN_DEPTH_RESET;
      max_depth_q <= dpb_pkg::MAX_DEPTH_RESET;
      center_x_q  <= '0;
      center_y_q  <= '0;
      inv_fx_q    <= '0;
      inv_fy_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dpb_pkg::REG_MIN_DEPTH:   min_depth_q <= pwdata[15:0];
        dpb_pkg::REG_MAX_DEPTH:   max_depth_q <= pwdata[15:0];
        dpb_pkg::REG_CENTER_X:    center_x_q  <= pwdata[15:0];
        dpb_pkg::REG_CENTER_Y:    center_y_q  <= pwdata[15:0];
        dpb_pkg::REG_INV_FOCAL_X: inv_fx_q    <= pwdata[23:0];
        dpb_pkg::REG_INV_FOCAL_Y: inv_fy_q    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dpb_pkg::REG_MIN_DEPTH:   prdata = {16'd0, min_depth_q};
      dpb_pkg::REG_MAX_DEPTH:   prdata = {16'd0, max_depth_q};
      dpb_pkg::REG_CENTER_X:    prdata = {16'd0, center_x_q};
      dpb_pkg::REG_CENTER_Y:    prdata = {16'd0, center_y_q};
      dpb_pkg::REG_INV_FOCAL_X: prdata = {8'd0, inv_fx_q};
      dpb_pkg::REG_INV_FOCAL_Y: prdata = {8'd0, inv_fy_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- stage control
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic v2_d;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o  = !en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v2_d;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ------------------------------------------- stage A: offsets, window test
  logic [CW-1:0] row_c, col_c;
  logic [15:0]   row_pos, col_pos;
  logic          xneg_d, yneg_d, win_d;
  logic [15:0]   xmag_d, ymag_d;
  logic [PW-1:0] row_prod_d, col_prod_d;

  assign row_c   = in_data_i.pixel_row[CW-1:0];
  assign col_c   = in_data_i.pixel_col[CW-1:0];
  assign row_pos = 16'({row_c, 4'b0000});
  assign col_pos = 16'({col_c, 4'b0000});

  always_comb begin
    xneg_d     = col_pos < center_x_q;
    yneg_d     = row_pos < center_y_q;
    xmag_d     = xneg_d ? (center_x_q - col_pos) : (col_pos - center_x_q);
    ymag_d     = yneg_d ? (center_y_q - row_pos) : (row_pos - center_y_q);
    win_d      = (in_data_i.depth_mm >= min_depth_q) && (in_data_i.depth_mm <= max_depth_q);
    row_prod_d = PW'(row_c) * PW'(DIV_MUL);
    col_prod_d = PW'(col_c) * PW'(DIV_MUL);
  end

  logic [15:0]   xmag1_q, ymag1_q, depth1_q;
  logic          xneg1_q, yneg1_q, win1_q;
  logic [PW-1:0] row_prod1_q, col_prod1_q;
  logic [7:0]    r1_q, g1_q, b1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      xmag1_q     <= xmag_d;
      ymag1_q     <= ymag_d;
      xneg1_q     <= xneg_d;
      yneg1_q     <= yneg_d;
      win1_q      <= win_d;
      row_prod1_q <= row_prod_d;
      col_prod1_q <= col_prod_d;
      depth1_q    <= in_data_i.depth_mm;
      r1_q        <= in_data_i.red;
      g1_q        <= in_data_i.green;
      b1_q        <= in_data_i.blue;
    end
  end

  // ------------------------------- stage B: offset times depth, subsample test
  logic [DIV_SHIFT-1:0] row_frac, col_frac;
  logic                 sub_ok;

  assign row_frac = row_prod1_q[DIV_SHIFT-1:0];
  assign col_frac = col_prod1_q[DIV_SHIFT-1:0];
  assign sub_ok   = (PW'(row_frac) < PW'(DIV_MUL)) && (PW'(col_frac) < PW'(DIV_MUL));
  assign v2_d     = v1_q && win1_q && sub_ok;

  logic [31:0] xmd2_q, ymd2_q;
  logic        xneg2_q, yneg2_q;
  logic [15:0] depth2_q;
  logic [7:0]  r2_q, g2_q, b2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      xmd2_q   <= 32'(xmag1_q) * 32'(depth1_q);
      ymd2_q   <= 32'(ymag1_q) * 32'(depth1_q);
      xneg2_q  <= xneg1_q;
      yneg2_q  <= yneg1_q;
      depth2_q <= depth1_q;
      r2_q     <= r1_q;
      g2_q     <= g1_q;
      b2_q     <= b1_q;
    end
  end

  // --------------------------------------- stage C: times inverse focal length
  logic [PB-1:0] xp3_q, yp3_q;
  logic          xneg3_q, yneg3_q;
  logic [15:0]   depth3_q;
  logic [7:0]    r3_q, g3_q, b3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      xp3_q    <= PB'(xmd2_q) * PB'(inv_fx_q);
      yp3_q    <= PB'(ymd2_q) * PB'(inv_fy_q);
      xneg3_q  <= xneg2_q;
      yneg3_q  <= yneg2_q;
      depth3_q <= depth2_q;
      r3_q     <= r2_q;
      g3_q     <= g2_q;
      b3_q     <= b2_q;
    end
  end

  // ------------------------------------------ stage D: floor to integer mm
  // The magnitude has at most 28 integer bits, so the 32-bit result never
  // saturates. A negative coordinate rounds its magnitude up, which floors.
  function automatic logic [31:0] floor_axis(input logic [PB-1:0] p, input logic neg);
    logic [PB-FB:0] q;
    q = {1'b0, p[PB-1:FB]} + (PB-FB+1)'(neg && (p[FB-1:0] != '0));
    return neg ? (32'd0 - 32'(q)) : 32'(q);
  endfunction

  dpb_pkg::point_t out_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      out_q.x_mm        <= floor_axis(xp3_q, xneg3_q);
      out_q.y_mm        <= floor_axis(yp3_q, yneg3_q);
      out_q.z_mm        <= depth3_q;
      out_q.point_red   <= r3_q;
      out_q.point_green <= g3_q;
      out_q.point_blue  <= b3_q;
    end
  end

  assign out_data_o = out_q;

  // --------------------------------------------------------------- checks
  `DPB_ASSERT_IMP(a_stall_only_when_full, in_stall_o, v1_q && v2_q && v3_q && v4_q && out_stall_i, "input stalled while the pipeline has a free stage")
  `DPB_ASSERT_IMP(a_no_stall_when_out_empty, !out_valid_o, !in_stall_o, "input stalled although the output register is empty")
  `DPB_ASSERT_NEXT(a_stage_advances, v3_q && !out_stall_i, out_valid_o, "item in the last stage did not reach the output")
  `DPB_ASSERT_NEXT(a_bubble_kept, !v3_q && (!v4_q || !out_stall_i), !out_valid_o, "output valid without an item behind it")

endmodule

`default_nettype wire
